// File: src/tcp_responder_connection_table_core_macros.svh
// ----------------------------------------------------------------------------
// TCP responder connection table - assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TCP_RESPONDER_CONNECTION_TABLE_CORE_MACROS_SVH
`define TCP_RESPONDER_CONNECTION_TABLE_CORE_MACROS_SVH

// property must hold
`define TCPRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen
`define TCPRC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: src/tcprc_pkg.sv
// ----------------------------------------------------------------------------
// tcprc_pkg
// Types, codes and constants shared by the TCP responder connection table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcprc_pkg;

    localparam int NUM_CONNS_DEF = 2;
    localparam int ADDR_W        = 4;
    localparam int CSUM_WORDS    = 15;

    localparam logic [5:0] F_FIN = 6'h01;
    localparam logic [5:0] F_SYN = 6'h02;
    localparam logic [5:0] F_PSH = 6'h08;
    localparam logic [5:0] F_ACK = 6'h10;

    localparam logic [15:0] TCP_PROTO     = 16'd6;
    localparam logic [15:0] TCP_HDR_BYTES = 16'd20;
    localparam logic [15:0] TCP_WINDOW    = 16'd1500;
    localparam logic [7:0]  TCP_DOFF      = 8'h50;
    localparam logic [31:0] IP_HDR_BYTES  = 32'd20;

    localparam logic [15:0] APP_PORT_RST    = 16'd23;
    localparam logic [10:0] MAX_PAYLOAD_RST = 11'd768;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_SLOT = 2'd1,
        STAT_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_CLOSE  = 2'd2,
        EV_DATA   = 2'd3
    } app_event_t;

    typedef enum logic [1:0] {
        PH_FREE    = 2'd0,
        PH_OPEN    = 2'd1,
        PH_CLOSING = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        REG_LOCAL_IP    = 2'd0,
        REG_APP_PORT    = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [15:0] own_port;
        logic [31:0] next_seq;
        logic [31:0] last_ack;
    } slot_rd_t;

    typedef struct packed {
        logic        phase_we;
        phase_t      phase;
        logic        tuple_we;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [15:0] own_port;
        logic        seq_we;
        logic [31:0] next_seq;
        logic        ack_we;
        logic [31:0] last_ack;
    } slot_wr_t;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [31:0] remote_ip;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
        logic [10:0] len;
        logic [15:0] psum;
    } hdr_t;

endpackage

// File: src/tcp_responder_connection_table_core.sv
// ----------------------------------------------------------------------------
// tcp_responder_connection_table_core
// TCP server connection table: SYN/FIN/PSH handling, send requests and the
// header checksum, computed one word per cycle.
// ----------------------------------------------------------------------------
// Channel   Handshake                     Transaction
// command   start, busy                   action .. payload_sum
// result    done (one-cycle strobe)       send_segment .. checksum
// config    psel, penable, pwrite, pready local_ip, app_port, max_payload
//
// A send request passes through the decode state, the checksum state (one
// word at a time through the ones-complement adder) and the result state.
// A received segment first scans the slots from slot 0 to a match or the last
// slot, ahead of decode; when nothing is sent the checksum state is skipped.
// busy is high from the accepting edge through done and low in the cycle after.
// No reset sweep: slot phases clear at once on rst_n; the result is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_responder_connection_table_core #(
    parameter int NUM_CONNS = tcprc_pkg::NUM_CONNS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          action,
    input  logic [31:0]                   src_ip,
    input  logic [15:0]                   src_port,
    input  logic [15:0]                   dst_port,
    input  logic [5:0]                    seg_flags,
    input  logic [31:0]                   seg_seq,
    input  logic [15:0]                   ip_total_len,
    input  logic [3:0]                    header_words,
    input  logic                          conn_sel,
    input  logic [10:0]                   send_len,
    input  logic                          send_fin,
    input  logic [15:0]                   payload_sum,
    output logic                          send_segment,
    output logic [1:0]                    status,
    output logic                          conn_index,
    output logic [1:0]                    app_event,
    output logic [31:0]                   remote_ip,
    output logic [15:0]                   local_port,
    output logic [15:0]                   remote_port,
    output logic [31:0]                   seq_num,
    output logic [31:0]                   ack_num,
    output logic [5:0]                    tcp_flags,
    output logic [15:0]                   checksum,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcprc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IDX_W = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;

    tcprc_pkg::state_t      state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg;
    logic                   found_reg;

    logic                   accept;
    logic                   scan_en;
    logic                   exec_en;
    logic                   scan_hit;
    logic                   scan_last;
    logic                   syn_req;
    logic                   sel_ok;
    logic                   csum_done;
    logic [15:0]            csum_sum;

    logic                   action_reg;
    logic [31:0]            sip_reg;
    logic [15:0]            sport_reg;
    logic [15:0]            dport_reg;
    logic [5:0]             iflags_reg;
    logic [31:0]            sseq_reg;
    logic [31:0]            dlen_reg;
    logic [10:0]            slen_reg;
    logic                   sfin_reg;
    logic [15:0]            ipsum_reg;

    logic                   send_reg;
    tcprc_pkg::status_t     status_reg;
    logic                   conn_reg;
    tcprc_pkg::app_event_t  event_reg;
    logic [31:0]            rip_reg;
    logic [15:0]            lport_reg;
    logic [15:0]            rport_reg;
    logic [31:0]            seq_reg;
    logic [31:0]            ack_reg;
    logic [5:0]             oflags_reg;
    logic [10:0]            len_reg;
    logic [15:0]            psum_reg;

    logic [31:0]            local_ip_reg;
    logic [15:0]            app_port_reg;
    logic [10:0]            max_payload_reg;
    logic                   cfg_we;
    tcprc_pkg::cfg_reg_t    cfg_idx;

    logic                   ex_send;
    tcprc_pkg::status_t     ex_status;
    logic                   ex_conn;
    tcprc_pkg::app_event_t  ex_event;
    logic [31:0]            ex_rip;
    logic [15:0]            ex_lport;
    logic [15:0]            ex_rport;
    logic [31:0]            ex_seq;
    logic [31:0]            ex_ack;
    logic [5:0]             ex_flags;
    logic [10:0]            ex_len;
    logic [15:0]            ex_psum;
    logic [10:0]            clip_len;
    logic [31:0]            ack_add;
    logic [31:0]            ack_rx;
    logic                   app_hit;

    tcprc_pkg::slot_rd_t    rd;
    tcprc_pkg::slot_wr_t    wr;
    tcprc_pkg::hdr_t        hdr;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = tcprc_pkg::cfg_reg_t'(paddr[tcprc_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg    <= '0;
            app_port_reg    <= tcprc_pkg::APP_PORT_RST;
            max_payload_reg <= tcprc_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tcprc_pkg::REG_LOCAL_IP:    local_ip_reg    <= pwdata;
                tcprc_pkg::REG_APP_PORT:    app_port_reg    <= pwdata[15:0];
                tcprc_pkg::REG_MAX_PAYLOAD: max_payload_reg <= pwdata[10:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            tcprc_pkg::REG_LOCAL_IP:    prdata = local_ip_reg;
            tcprc_pkg::REG_APP_PORT:    prdata = {16'd0, app_port_reg};
            tcprc_pkg::REG_MAX_PAYLOAD: prdata = {21'd0, max_payload_reg};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcprc_pkg::ST_IDLE:
                if (accept)
                begin
                    state_next = action ? tcprc_pkg::ST_EXEC : tcprc_pkg::ST_SCAN;
                end
            tcprc_pkg::ST_SCAN:
                if (scan_hit || scan_last)
                begin
                    state_next = tcprc_pkg::ST_EXEC;
                end
            tcprc_pkg::ST_EXEC:
                state_next = ex_send ? tcprc_pkg::ST_SUM : tcprc_pkg::ST_DONE;
            tcprc_pkg::ST_SUM:
                if (csum_done)
                begin
                    state_next = tcprc_pkg::ST_DONE;
                end
            tcprc_pkg::ST_DONE:
                state_next = tcprc_pkg::ST_IDLE;
            default:
                state_next = tcprc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy    = 1'b1;
        done    = 1'b0;
        scan_en = 1'b0;
        exec_en = 1'b0;
        unique case (state_reg)
            tcprc_pkg::ST_IDLE: busy    = 1'b0;
            tcprc_pkg::ST_SCAN: scan_en = 1'b1;
            tcprc_pkg::ST_EXEC: exec_en = 1'b1;
            tcprc_pkg::ST_SUM:  ;
            tcprc_pkg::ST_DONE: done    = 1'b1;
            default:            busy    = 1'b0;
        endcase
    end

    assign accept    = start & ~busy;
    assign sel_ok    = (NUM_CONNS > 1) || !conn_sel;
    assign syn_req   = (iflags_reg & tcprc_pkg::F_SYN) != 6'd0;
    assign scan_last = (idx_reg == IDX_W'(NUM_CONNS - 1));
    assign scan_hit  = syn_req ? (rd.phase == tcprc_pkg::PH_FREE)
                               : (rd.phase != tcprc_pkg::PH_FREE &&
                                  rd.peer_ip == sip_reg &&
                                  rd.own_port == dport_reg &&
                                  rd.peer_port == sport_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcprc_pkg::ST_IDLE;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                // segments scan from slot 0, sends go straight to their slot
                idx_reg   <= (action && sel_ok) ? IDX_W'(conn_sel) : '0;
                found_reg <= sel_ok;
            end
            else if (scan_en)
            begin
                found_reg <= scan_hit;
                if (!scan_hit && !scan_last)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // ---------------- transaction capture ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            sip_reg    <= src_ip;
            sport_reg  <= src_port;
            dport_reg  <= dst_port;
            iflags_reg <= seg_flags;
            sseq_reg   <= seg_seq;
            dlen_reg   <= 32'(ip_total_len) - tcprc_pkg::IP_HDR_BYTES
                          - 32'({header_words, 2'b00});
            slen_reg   <= send_len;
            sfin_reg   <= send_fin;
            ipsum_reg  <= payload_sum;
        end
    end

    // ---------------- decode and slot update ----------------
    assign clip_len = (slen_reg > max_payload_reg) ? max_payload_reg : slen_reg;
    assign ack_add  = ((iflags_reg & (tcprc_pkg::F_SYN | tcprc_pkg::F_FIN)) != 6'd0)
                      ? 32'd1 : dlen_reg;
    assign ack_rx   = sseq_reg + ack_add;
    assign app_hit  = (dport_reg == app_port_reg);

    always_comb
    begin
        ex_send   = 1'b0;
        ex_status = tcprc_pkg::STAT_OK;
        ex_conn   = idx_reg[0];
        ex_event  = tcprc_pkg::EV_NONE;
        ex_rip    = sip_reg;
        ex_lport  = dport_reg;
        ex_rport  = sport_reg;
        ex_seq    = rd.next_seq;
        ex_ack    = ack_rx;
        ex_flags  = tcprc_pkg::F_ACK;
        ex_len    = '0;
        ex_psum   = '0;
        wr        = '0;

        if (action_reg)
        begin
            if (!found_reg || rd.phase == tcprc_pkg::PH_FREE)
            begin
                ex_status = tcprc_pkg::STAT_UNKNOWN;
                ex_conn   = 1'b0;
            end
            else
            begin
                ex_send     = 1'b1;
                ex_rip      = rd.peer_ip;
                ex_lport    = rd.own_port;
                ex_rport    = rd.peer_port;
                ex_ack      = rd.last_ack;
                ex_len      = clip_len;
                ex_psum     = ipsum_reg;
                ex_flags    = tcprc_pkg::F_ACK
                              | (sfin_reg ? tcprc_pkg::F_FIN : 6'd0)
                              | ((clip_len != 11'd0) ? tcprc_pkg::F_PSH : 6'd0);
                wr.seq_we   = 1'b1;
                wr.next_seq = rd.next_seq + 32'(clip_len);
            end
        end
        else if (syn_req)
        begin
            if (!found_reg)
            begin
                ex_status = tcprc_pkg::STAT_NO_SLOT;
                ex_conn   = 1'b0;
            end
            else
            begin
                ex_send      = 1'b1;
                ex_seq       = 32'd1;
                ex_flags     = tcprc_pkg::F_ACK | tcprc_pkg::F_SYN
                               | (iflags_reg & tcprc_pkg::F_FIN);
                ex_event     = app_hit ? tcprc_pkg::EV_ACCEPT : tcprc_pkg::EV_NONE;
                wr.phase_we  = 1'b1;
                wr.phase     = tcprc_pkg::PH_OPEN;
                wr.tuple_we  = 1'b1;
                wr.peer_ip   = sip_reg;
                wr.peer_port = sport_reg;
                wr.own_port  = dport_reg;
                wr.ack_we    = 1'b1;
                wr.last_ack  = ack_rx;
                wr.seq_we    = 1'b1;
                wr.next_seq  = 32'd2;
            end
        end
        else if (!found_reg)
        begin
            ex_status = tcprc_pkg::STAT_UNKNOWN;
            ex_conn   = 1'b0;
        end
        else if ((iflags_reg & tcprc_pkg::F_ACK) != 6'd0 &&
                 rd.phase == tcprc_pkg::PH_CLOSING)
        begin
            wr.phase_we = 1'b1;
            wr.phase    = tcprc_pkg::PH_FREE;
        end
        else if ((iflags_reg & tcprc_pkg::F_FIN) != 6'd0)
        begin
            ex_send     = 1'b1;
            ex_flags    = tcprc_pkg::F_ACK | tcprc_pkg::F_FIN;
            ex_event    = app_hit ? tcprc_pkg::EV_CLOSE : tcprc_pkg::EV_NONE;
            wr.phase_we = 1'b1;
            wr.phase    = tcprc_pkg::PH_CLOSING;
            wr.ack_we   = 1'b1;
            wr.last_ack = ack_rx;
        end
        else if ((iflags_reg & tcprc_pkg::F_PSH) != 6'd0)
        begin
            ex_send     = 1'b1;
            ex_event    = app_hit ? tcprc_pkg::EV_DATA : tcprc_pkg::EV_NONE;
            wr.ack_we   = 1'b1;
            wr.last_ack = ack_rx;
        end

        if (!ex_send)
        begin
            ex_rip   = '0;
            ex_lport = '0;
            ex_rport = '0;
            ex_seq   = '0;
            ex_ack   = '0;
            ex_flags = '0;
        end
        if (!exec_en)
        begin
            wr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            send_reg   <= ex_send;
            status_reg <= ex_status;
            conn_reg   <= ex_conn;
            event_reg  <= ex_event;
            rip_reg    <= ex_rip;
            lport_reg  <= ex_lport;
            rport_reg  <= ex_rport;
            seq_reg    <= ex_seq;
            ack_reg    <= ex_ack;
            oflags_reg <= ex_flags;
            len_reg    <= ex_len;
            psum_reg   <= ex_psum;
        end
    end

    tcprc_slots #(
        .NUM_CONNS (NUM_CONNS)
    ) u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (idx_reg),
        .wr    (wr),
        .rd    (rd)
    );

    // ---------------- checksum ----------------
    assign hdr.local_ip    = local_ip_reg;
    assign hdr.remote_ip   = rip_reg;
    assign hdr.local_port  = lport_reg;
    assign hdr.remote_port = rport_reg;
    assign hdr.seq         = seq_reg;
    assign hdr.ack         = ack_reg;
    assign hdr.flags       = oflags_reg;
    assign hdr.len         = len_reg;
    assign hdr.psum        = psum_reg;

    tcprc_csum u_csum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exec_en && ex_send),
        .hdr   (hdr),
        .done  (csum_done),
        .sum   (csum_sum)
    );

    // ---------------- result ----------------
    assign send_segment = send_reg;
    assign status       = status_reg;
    assign conn_index   = conn_reg;
    assign app_event    = event_reg;
    assign remote_ip    = rip_reg;
    assign local_port   = lport_reg;
    assign remote_port  = rport_reg;
    assign seq_num      = seq_reg;
    assign ack_num      = ack_reg;
    assign tcp_flags    = oflags_reg;
    assign checksum     = send_reg ? ~csum_sum : 16'd0;

endmodule

// File: src/tcprc_slots.sv
// ----------------------------------------------------------------------------
// tcprc_slots
// Per-slot connection state: phase with reset, peer IP, peer and own ports, and sequence stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcprc_slots #(
    parameter int NUM_CONNS = tcprc_pkg::NUM_CONNS_DEF,
    localparam int IDX_W = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     idx,
    input  tcprc_pkg::slot_wr_t  wr,
    output tcprc_pkg::slot_rd_t  rd
);

    tcprc_pkg::phase_t phase_reg     [NUM_CONNS];
    logic [31:0]       peer_ip_reg   [NUM_CONNS];
    logic [15:0]       peer_port_reg [NUM_CONNS];
    logic [15:0]       own_port_reg  [NUM_CONNS];
    logic [31:0]       next_seq_reg  [NUM_CONNS];
    logic [31:0]       last_ack_reg  [NUM_CONNS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CONNS; i++)
            begin
                phase_reg[i] <= tcprc_pkg::PH_FREE;
            end
        end
        else if (wr.phase_we)
        begin
            phase_reg[idx] <= wr.phase;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.tuple_we)
        begin
            peer_ip_reg[idx]   <= wr.peer_ip;
            peer_port_reg[idx] <= wr.peer_port;
            own_port_reg[idx]  <= wr.own_port;
        end
        if (wr.seq_we)
        begin
            next_seq_reg[idx] <= wr.next_seq;
        end
        if (wr.ack_we)
        begin
            last_ack_reg[idx] <= wr.last_ack;
        end
    end

    assign rd.phase     = phase_reg[idx];
    assign rd.peer_ip   = peer_ip_reg[idx];
    assign rd.peer_port = peer_port_reg[idx];
    assign rd.own_port  = own_port_reg[idx];
    assign rd.next_seq  = next_seq_reg[idx];
    assign rd.last_ack  = last_ack_reg[idx];

endmodule

// File: src/tcprc_csum.sv
// ----------------------------------------------------------------------------
// tcprc_csum
// Ones-complement checksum accumulator, one 16-bit word per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcprc_csum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tcprc_pkg::hdr_t   hdr,
    output logic              done,
    output logic [15:0]       sum
);

    localparam int WORD_W = $clog2(tcprc_pkg::CSUM_WORDS);

    logic                                  busy_reg;
    logic [WORD_W-1:0]                     word_reg;
    logic [15:0]                           sum_reg;
    logic [tcprc_pkg::CSUM_WORDS*16-1:0]   words;
    logic [15:0]                           word;
    logic [16:0]                           raw_sum;
    logic                                  last;

    // pseudo-header, header, payload sum
    assign words = {hdr.local_ip, hdr.remote_ip, tcprc_pkg::TCP_PROTO,
                    tcprc_pkg::TCP_HDR_BYTES + 16'(hdr.len),
                    hdr.local_port, hdr.remote_port, hdr.seq, hdr.ack,
                    tcprc_pkg::TCP_DOFF, 2'b00, hdr.flags,
                    tcprc_pkg::TCP_WINDOW, hdr.psum};

    assign word    = words[{word_reg, 4'b0000} +: 16];
    assign raw_sum = {1'b0, sum_reg} + {1'b0, word};
    assign last    = (word_reg == WORD_W'(tcprc_pkg::CSUM_WORDS - 1));
    assign done    = busy_reg && last;
    assign sum     = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            word_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            word_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                word_reg <= word_reg + WORD_W'(1);
            end
        end
    end

    // end-around carry
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= '0;
        end
        else if (busy_reg)
        begin
            sum_reg <= raw_sum[15:0] + {15'd0, raw_sum[16]};
        end
    end

endmodule

// File: src/tcprc_checker.sv
// ----------------------------------------------------------------------------
// tcprc_port_checks
// Port-level checks on the TCP responder connection table, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tcp_responder_connection_table_core_macros.svh"

module tcprc_port_checks (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          done,
    input logic                          send_segment,
    input logic [1:0]                    status,
    input logic [5:0]                    tcp_flags,
    input logic [15:0]                   checksum
);

    `TCPRC_ASSERT(a_done_in_transaction, done |-> busy,
                  "result strobe outside a transaction")

    `TCPRC_ASSERT(a_done_single_cycle, done |=> !done,
                  "result strobe longer than one cycle")

    `TCPRC_NEVER(a_quiet_header_zero,
                 done && !send_segment && (checksum != 16'd0 || tcp_flags != 6'd0),
                 "header fields set on a result with nothing sent")

    `TCPRC_ASSERT(a_sent_is_ok_ack,
                  done && send_segment |->
                      (tcp_flags & tcprc_pkg::F_ACK) != 6'd0 &&
                      status == tcprc_pkg::STAT_OK,
                  "sent header without ACK or with error status")

endmodule

bind tcp_responder_connection_table_core tcprc_port_checks u_tcprc_port_checks (.*);
